// ===== hdl/sha1_byte_stream_hasher_assert.svh =====
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_assert.svh
// Assertion macros used by the hasher's checker file. They expect the
// including scope to provide clk and rst.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, off during reset
`define SHA1BSH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 hasher assertion failed");

// next-cycle implication, off during reset
`define SHA1BSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 hasher assertion failed");

`endif

// ===== hdl/sha1bsh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Types, command/status structs and SHA-1 constants for the byte stream hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

  // input beat command
  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // input beat payload
  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } msg_t;

  // output beat payload
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // round groups of 20 rounds each
  typedef enum logic [1:0] {
    PH_CH   = 2'd0,
    PH_PAR1 = 2'd1,
    PH_MAJ  = 2'd2,
    PH_PAR2 = 2'd3
  } phase_t;

  // source of a byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic      push;
    byte_src_t src;
    logic      count;
    logic      load_work;
    logic      round;
    phase_t    phase;
    logic      final_add;
    logic      emit;
    logic [2:0] word_sel;
    logic      clear;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fill_last;
    logic fill_len;
    logic out_free;
  } dp_stat_t;

  localparam int unsigned HASH_WORDS    = 5;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;
  localparam logic [5:0]  LEN_POS       = 6'd56;
  localparam logic [5:0]  LAST_POS      = 6'd63;
  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam logic [4:0]  GROUP_LAST    = 5'd19;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  // initial chaining value
  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hefcdab89;
      3'd2:    w = 32'h98badcfe;
      3'd3:    w = 32'h10325476;
      3'd4:    w = 32'hc3d2e1f0;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  // round constant per group
  function automatic logic [31:0] round_k(input phase_t ph);
    logic [31:0] k;
    case (ph)
      PH_CH:   k = 32'h5a827999;
      PH_PAR1: k = 32'h6ed9eba1;
      PH_MAJ:  k = 32'h8f1bbcdc;
      PH_PAR2: k = 32'hca62c1d6;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/sha1_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream: absorb beats add message bytes, a finish beat pads
// the message and returns the five digest words H0..H4 as five output beats.
// ----------------------------------------------------------------------------
// The hasher takes an absorb beat whenever it is idle. The beat that completes
// a 64-byte block starts a compression that holds msg_stall: the round unit
// does one of the 80 rounds per cycle, then a final step adds the result into
// the chaining value. A finish beat shifts the padding and length bytes in at
// one byte per cycle (9 to 72 bytes), compresses one or two blocks, and then
// presents the digest words one per cycle as the output side takes them. After
// the fifth word is loaded the hasher is back in its initial state and accepts
// the next message while that word may still wait in the output register.
module sha1_byte_stream_hasher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_stall,
  input  sha1bsh_pkg::msg_t    msg,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output sha1bsh_pkg::digest_t digest
);

  sha1bsh_pkg::dp_cmd_t  cmd;
  sha1bsh_pkg::dp_stat_t stat;

  // sequencer
  sha1bsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .command   (msg.command),
    .stat      (stat),
    .cmd       (cmd)
  );

  // buffer, rounds and output register
  sha1bsh_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .msg          (msg),
    .cmd          (cmd),
    .stat         (stat),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

endmodule

// ===== hdl/sha1bsh_dp.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_dp
// Datapath: block buffer / message schedule shift line, round unit, chaining
// value, bit counter and the digest output register.
// ----------------------------------------------------------------------------
module sha1bsh_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1bsh_pkg::msg_t    msg,
  input  sha1bsh_pkg::dp_cmd_t cmd,
  output sha1bsh_pkg::dp_stat_t stat,
  output logic                 digest_valid,
  input  logic                 digest_stall,
  output sha1bsh_pkg::digest_t digest
);

  logic [511:0] wbuf;
  logic [31:0]  h [sha1bsh_pkg::HASH_WORDS];
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  logic [31:0]  a, b, c, d, e;

  logic [7:0]   len_byte;
  logic [7:0]   push_byte;
  logic [31:0]  w0, w2, w8, w13, wmix, wnew;
  logic [31:0]  f, t;

  // length byte for buffer positions 56..63, most significant first
  assign len_byte = bit_count[{~fill[2:0], 3'b000} +: 8];

  // byte source select
  always_comb begin
    case (cmd.src)
      sha1bsh_pkg::SRC_DATA: push_byte = msg.data_byte;
      sha1bsh_pkg::SRC_PAD:  push_byte = sha1bsh_pkg::PAD_BYTE;
      sha1bsh_pkg::SRC_ZERO: push_byte = 8'h00;
      sha1bsh_pkg::SRC_LEN:  push_byte = len_byte;
      default:               push_byte = 8'h00;
    endcase
  end

  // schedule taps, oldest word at the top of the shift line
  assign w0   = wbuf[511:480];
  assign w2   = wbuf[447:416];
  assign w8   = wbuf[255:224];
  assign w13  = wbuf[95:64];
  assign wmix = w13 ^ w8 ^ w2 ^ w0;
  assign wnew = {wmix[30:0], wmix[31]};

  // round function
  always_comb begin
    case (cmd.phase)
      sha1bsh_pkg::PH_CH:  f = (b & c) | (~b & d);
      sha1bsh_pkg::PH_MAJ: f = (b & c) | (b & d) | (c & d);
      default:             f = b ^ c ^ d;
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + sha1bsh_pkg::round_k(cmd.phase) + w0;

  // buffer bytes in, then one schedule word per round
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      wbuf <= {wbuf[503:0], push_byte};
    end else if (cmd.round) begin
      wbuf <= {wbuf[479:0], wnew};
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < sha1bsh_pkg::HASH_WORDS; i++) begin
        h[i] <= sha1bsh_pkg::init_word(3'(i));
      end
    end else if (cmd.final_add) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      h[4] <= h[4] + e;
    end
  end

  // fill position and message length
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill      <= '0;
      bit_count <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count) begin
        bit_count <= bit_count + sha1bsh_pkg::BITS_PER_BYTE;
      end
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (cmd.emit) begin
      digest_valid <= 1'b1;
    end else if (!digest_stall) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest.digest_word <= h[cmd.word_sel];
      digest.word_index  <= cmd.word_sel;
      digest.last_word   <= (cmd.word_sel == sha1bsh_pkg::LAST_WORD_IDX);
    end
  end

  // status back to the controller
  assign stat.fill_last = (fill == sha1bsh_pkg::LAST_POS);
  assign stat.fill_len  = (fill == sha1bsh_pkg::LEN_POS);
  assign stat.out_free  = !digest_valid || !digest_stall;

endmodule

// ===== hdl/sha1bsh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_ctrl
// Controller: accepts beats, sequences the 80 rounds, the padding bytes and
// the five digest words.
// ----------------------------------------------------------------------------
module sha1bsh_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  sha1bsh_pkg::cmd_t     command,
  input  sha1bsh_pkg::dp_stat_t stat,
  output sha1bsh_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_FINAL = 5'b00100,
    S_PAD   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic                finishing, finishing_next;
  logic                len_phase, len_phase_next;
  sha1bsh_pkg::phase_t phase, phase_next;
  logic [4:0]          sub, sub_next;
  logic [2:0]          widx, widx_next;

  assign msg_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd            = '0;
    cmd.phase      = phase;
    cmd.word_sel   = widx;
    state_next     = state;
    finishing_next = finishing;
    len_phase_next = len_phase;
    widx_next      = widx;
    unique case (state)
      S_IDLE: begin
        if (msg_valid) begin
          cmd.push = 1'b1;
          if (command == sha1bsh_pkg::CMD_ABSORB) begin
            cmd.src   = sha1bsh_pkg::SRC_DATA;
            cmd.count = 1'b1;
          end else begin
            cmd.src        = sha1bsh_pkg::SRC_PAD;
            finishing_next = 1'b1;
            state_next     = S_PAD;
          end
          if (stat.fill_last) begin
            cmd.load_work = 1'b1;
            state_next    = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (phase == sha1bsh_pkg::PH_PAR2 && sub == sha1bsh_pkg::GROUP_LAST) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.final_add = 1'b1;
        if (!finishing) begin
          state_next = S_IDLE;
        end else if (len_phase) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.push = 1'b1;
        // length field starts at position 56 of the final block
        if (len_phase || stat.fill_len) begin
          cmd.src        = sha1bsh_pkg::SRC_LEN;
          len_phase_next = 1'b1;
        end else begin
          cmd.src = sha1bsh_pkg::SRC_ZERO;
        end
        if (stat.fill_last) begin
          cmd.load_work = 1'b1;
          state_next    = S_ROUND;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          widx_next = widx + 3'd1;
          if (widx == sha1bsh_pkg::LAST_WORD_IDX) begin
            cmd.clear      = 1'b1;
            widx_next      = '0;
            finishing_next = 1'b0;
            len_phase_next = 1'b0;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // round counters: 20 rounds per group, four groups
  always_comb begin
    phase_next = sha1bsh_pkg::PH_CH;
    sub_next   = '0;
    if (state == S_ROUND) begin
      if (sub == sha1bsh_pkg::GROUP_LAST) begin
        phase_next = sha1bsh_pkg::phase_t'(phase + 2'd1);
      end else begin
        phase_next = phase;
        sub_next   = sub + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      finishing <= 1'b0;
      len_phase <= 1'b0;
      phase     <= sha1bsh_pkg::PH_CH;
      sub       <= '0;
      widx      <= '0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
      len_phase <= len_phase_next;
      phase     <= phase_next;
      sub       <= sub_next;
      widx      <= widx_next;
    end
  end

endmodule

// ===== hdl/sha1bsh_checker.sv =====
// ----------------------------------------------------------------------------
// sha1bsh_checker
// Port-level checks of the hasher, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "sha1_byte_stream_hasher_assert.svh"

module sha1bsh_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 msg_valid,
  input logic                 msg_stall,
  input sha1bsh_pkg::msg_t    msg,
  input logic                 digest_valid,
  input logic                 digest_stall,
  input sha1bsh_pkg::digest_t digest
);

  // a stalled digest beat holds
  `SHA1BSH_ASSERT_NEXT(a_digest_hold, digest_valid && digest_stall, digest_valid && $stable(digest))

  // last flag marks exactly the fifth word
  `SHA1BSH_ASSERT_NOW(a_last_flag, digest_valid, digest.last_word == (digest.word_index == sha1bsh_pkg::LAST_WORD_IDX))

  // words follow one another back to back in order
  `SHA1BSH_ASSERT_NEXT(a_word_order, digest_valid && !digest_stall && !digest.last_word, digest_valid && digest.word_index == $past(digest.word_index) + 3'd1)

  // input held off while the digest is still going out
  `SHA1BSH_ASSERT_NOW(a_busy_emit, digest_valid && !digest.last_word, msg_stall)

  // a finish beat always makes the hasher busy
  `SHA1BSH_ASSERT_NEXT(a_finish_busy, msg_valid && !msg_stall && msg.command == sha1bsh_pkg::CMD_FINISH, msg_stall)

endmodule

bind sha1_byte_stream_hasher sha1bsh_checker u_sha1bsh_checker (.*);
